### rtl/core/mcfe_pkg.sv
`default_nettype none

package mcfe_pkg;

    // Request codes on req_type
    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_DRIVE = 2'd1;
    localparam logic [1:0] REQ_BRAKE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_FREQUENCY  = 1'b1;

    // Register reset values
    localparam logic [15:0] PULSES_PER_REV_RST = 16'd2496;
    localparam logic [15:0] PWM_FREQUENCY_RST  = 16'd20000;

    // Frame bytes and opcodes
    localparam logic [7:0] HDR0       = 8'hAA;
    localparam logic [7:0] HDR1       = 8'h55;
    localparam logic [7:0] OP_INIT    = 8'h01;
    localparam logic [7:0] OP_CONFIG  = 8'h02;
    localparam logic [7:0] OP_BRAKE   = 8'h12;
    localparam logic [7:0] OP_SPEEDS  = 8'h13;
    localparam logic [7:0] BRAKE_BOTH = 8'h02;

    // Speed saturation limits
    localparam logic signed [15:0] SPEED_MAX = 16'sd255;
    localparam logic signed [15:0] SPEED_MIN = -16'sd255;

    // Byte index inside one job, up to fourteen bytes
    localparam int unsigned IDX_W = 4;

    // Job lengths in bytes
    localparam logic [IDX_W-1:0] LEN_INIT  = 4'd14;
    localparam logic [IDX_W-1:0] LEN_DRIVE = 4'd9;
    localparam logic [IDX_W-1:0] LEN_BRAKE = 4'd6;
    // Bytes in the INIT frame ahead of the CONFIG frame
    localparam logic [IDX_W-1:0] INIT_FRAME_LEN = 4'd5;

    typedef enum logic [1:0] {
        JOB_INIT,
        JOB_DRIVE,
        JOB_BRAKE
    } job_kind_t;

    // Classified command handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] word_a;   // pulses_per_rev or saturated left speed
        logic [15:0] word_b;   // pwm_frequency or saturated right speed
    } job_t;

endpackage

`default_nettype wire

### rtl/core/mcfe_front.sv
`default_nettype none

module mcfe_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    req_type,
    input  wire logic signed [15:0]            wheel_speed_l,
    input  wire logic signed [15:0]            wheel_speed_r,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mcfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    // job push toward the queue
    output logic                               push_valid,
    input  wire logic                          push_ready,
    output mcfe_pkg::job_t                     push_job
);

    logic [15:0] pulses_per_rev_reg;
    logic [15:0] pwm_frequency_reg;
    logic        link_ready_reg;
    logic        link_ready_next;
    logic        accept;
    logic        emits;

    function automatic logic [15:0] sat_speed(input logic signed [15:0] v);
        logic [15:0] r;
        if (v > mcfe_pkg::SPEED_MAX) begin
            r = mcfe_pkg::SPEED_MAX;
        end else if (v < mcfe_pkg::SPEED_MIN) begin
            r = mcfe_pkg::SPEED_MIN;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Registers take writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pulses_per_rev_reg <= mcfe_pkg::PULSES_PER_REV_RST;
            pwm_frequency_reg  <= mcfe_pkg::PWM_FREQUENCY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mcfe_pkg::REG_PULSES_PER_REV: pulses_per_rev_reg <= cfg_data;
                mcfe_pkg::REG_PWM_FREQUENCY:  pwm_frequency_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a transaction whenever the queue has room; drop silent ones
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Classify the request and build the job
    always_comb begin
        emits           = 1'b0;
        link_ready_next = link_ready_reg;
        push_job.kind   = mcfe_pkg::JOB_INIT;
        push_job.word_a = pulses_per_rev_reg;
        push_job.word_b = pwm_frequency_reg;
        case (req_type)
            mcfe_pkg::REQ_INIT: begin
                emits = 1'b1;
                if (accept) begin
                    link_ready_next = 1'b1;
                end
            end
            mcfe_pkg::REQ_DRIVE: begin
                emits           = link_ready_reg;
                push_job.kind   = mcfe_pkg::JOB_DRIVE;
                push_job.word_a = sat_speed(wheel_speed_l);
                push_job.word_b = sat_speed(wheel_speed_r);
            end
            mcfe_pkg::REQ_BRAKE: begin
                emits         = link_ready_reg;
                push_job.kind = mcfe_pkg::JOB_BRAKE;
            end
            default: ;
        endcase
    end

    assign push_valid = in_valid && emits;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            link_ready_reg <= 1'b0;
        end else begin
            link_ready_reg <= link_ready_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mcfe_queue.sv
`default_nettype none

module mcfe_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mcfe_pkg::job_t push_job,
    output logic                pop_valid,
    input  wire logic           pop_take,
    output mcfe_pkg::job_t      pop_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mcfe_pkg::job_t    slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_take && pop_valid;

    // Store the pushed job
    always_ff @(posedge clk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

endmodule

`default_nettype wire

### rtl/core/mcfe_back.sv
`default_nettype none

module mcfe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // job from the queue
    input  wire logic           pop_valid,
    output logic                pop_take,
    input  wire mcfe_pkg::job_t pop_job,
    // byte stream
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          tx_byte,
    output logic                last_byte
);

    mcfe_pkg::job_t                 job_reg;
    logic                           busy_reg;
    logic                           busy_next;
    logic [mcfe_pkg::IDX_W-1:0]     idx_reg;
    logic [mcfe_pkg::IDX_W-1:0]     idx_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [7:0]                     out_byte_reg;
    logic                           out_last_reg;
    logic                           advance;
    logic                           is_last;

    function automatic logic [mcfe_pkg::IDX_W-1:0] job_len(input mcfe_pkg::job_kind_t k);
        logic [mcfe_pkg::IDX_W-1:0] n;
        case (k)
            mcfe_pkg::JOB_INIT:  n = mcfe_pkg::LEN_INIT;
            mcfe_pkg::JOB_DRIVE: n = mcfe_pkg::LEN_DRIVE;
            mcfe_pkg::JOB_BRAKE: n = mcfe_pkg::LEN_BRAKE;
            default:             n = mcfe_pkg::LEN_BRAKE;
        endcase
        return n;
    endfunction

    // Pick one byte of the job's frame stream
    function automatic logic [7:0] frame_byte(input mcfe_pkg::job_t j,
                                              input logic [mcfe_pkg::IDX_W-1:0] idx);
        logic [7:0]                 op;
        logic [7:0]                 len;
        logic [31:0]                pl;
        logic [mcfe_pkg::IDX_W-1:0] off;
        logic [7:0]                 chk;
        logic [7:0]                 pb;
        logic [mcfe_pkg::IDX_W-1:0] pidx;
        logic [7:0]                 b;
        off = idx;
        case (j.kind)
            mcfe_pkg::JOB_INIT: begin
                if (idx < mcfe_pkg::INIT_FRAME_LEN) begin
                    op  = mcfe_pkg::OP_INIT;
                    len = 8'd0;
                    pl  = 32'd0;
                end else begin
                    op  = mcfe_pkg::OP_CONFIG;
                    len = 8'd4;
                    pl  = {j.word_a, j.word_b};
                    off = idx - mcfe_pkg::INIT_FRAME_LEN;
                end
            end
            mcfe_pkg::JOB_DRIVE: begin
                op  = mcfe_pkg::OP_SPEEDS;
                len = 8'd4;
                pl  = {j.word_a, j.word_b};
            end
            default: begin
                op  = mcfe_pkg::OP_BRAKE;
                len = 8'd1;
                pl  = {mcfe_pkg::BRAKE_BOTH, 24'd0};
            end
        endcase
        chk  = op ^ len ^ pl[31:24] ^ pl[23:16] ^ pl[15:8] ^ pl[7:0];
        pidx = off - 4'd4;
        case (pidx[1:0])
            2'd0:    pb = pl[31:24];
            2'd1:    pb = pl[23:16];
            2'd2:    pb = pl[15:8];
            default: pb = pl[7:0];
        endcase
        case (off)
            4'd0:    b = mcfe_pkg::HDR0;
            4'd1:    b = mcfe_pkg::HDR1;
            4'd2:    b = op;
            4'd3:    b = len;
            default: b = ({4'd0, off} < len + 8'd4) ? pb : chk;
        endcase
        return b;
    endfunction

    // Produce a byte when the output register is free or being drained
    assign advance  = busy_reg && (!out_valid_reg || out_ready);
    assign is_last  = (idx_reg == job_len(job_reg.kind) - 1'b1);
    assign pop_take = pop_valid && (!busy_reg || (advance && is_last));

    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (pop_take) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold job and output payload
    always_ff @(posedge clk) begin
        if (pop_take) begin
            job_reg <= pop_job;
        end
        if (advance) begin
            out_byte_reg <= frame_byte(job_reg, idx_reg);
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = out_byte_reg;
    assign last_byte = out_last_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg < job_len(job_reg.kind)))
        else $error("byte index past job length");

    a_first_is_header: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (idx_reg == '0) |=> (out_byte_reg == mcfe_pkg::HDR0) && out_valid_reg)
        else $error("frame does not open with header byte");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> !busy_reg || (idx_reg == '0))
        else $error("job still running after its final byte");

endmodule

`default_nettype wire

### rtl/core/motor_command_frame_encoder_unit.sv
// An accepted command passes the job queue and the back end's job register; its
// first byte then enters the output register. Bytes leave one per cycle while
// out_ready holds: init 14 bytes, drive 9, brake 6, and jobs stream with no gap.
// Commands that emit nothing (drive or brake before init, code 3) make no job.
// Reset (rst_n, async, low) clears link_ready, the job queue and the byte stream,
// and loads pulses_per_rev = 2496 and pwm_frequency = 20000.
`default_nettype none

module motor_command_frame_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // command channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     req_type,
    input  wire logic signed [15:0]             wheel_speed_l,
    input  wire logic signed [15:0]             wheel_speed_r,
    // byte channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          tx_byte,
    output logic                                last_byte,
    // configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mcfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data
);

    logic           push_valid;
    logic           push_ready;
    mcfe_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_take;
    mcfe_pkg::job_t pop_job;

    // Accept and classify commands
    mcfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .wheel_speed_l(wheel_speed_l),
        .wheel_speed_r(wheel_speed_r),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    // Buffer jobs between front and back
    mcfe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .pop_valid (pop_valid),
        .pop_take  (pop_take),
        .pop_job   (pop_job)
    );

    // Serialize frames one byte per cycle while out_ready holds
    mcfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_valid(pop_valid),
        .pop_take (pop_take),
        .pop_job  (pop_job),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tx_byte  (tx_byte),
        .last_byte(last_byte)
    );

endmodule

`default_nettype wire
